// ===== hw/rtl/clrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrq_pkg
// Shared types and constants for the C-LOOK request queue.
// ----------------------------------------------------------------------------
package clrq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int SECTOR_W = 48;
	localparam int LENGTH_W = 16;
	localparam int TAG_W    = 8;
	localparam int STATUS_W = 2;

	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NONE       = 2'd3;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [LENGTH_W-1:0] length;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // take the incoming word, clear the walk
		logic scan_ev;   // compare the entry just read, shift if past the slot
		logic append;    // write the carried entry at the tail, report added
		logic pop_ev;    // take the front entry, advance base, move head
		logic set_full;  // report refusal
		logic set_none;  // report nothing to dispatch
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_end;
	} dp_stat_t;

endpackage

// ===== hw/rtl/clrq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrq_ctrl
// Sequencer for the request queue: steps the insertion walk and dispatch.
// ----------------------------------------------------------------------------
module clrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                command,
	input  clrq_pkg::dp_stat_t  stat,
	output clrq_pkg::dp_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_POPRD = 3'd3;
	localparam logic [2:0] S_POPEV = 3'd4;

	logic [2:0] state_q, state_d;
	logic       done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (command == clrq_pkg::CMD_ADD) begin
						if (stat.full) begin
							cmd.set_full = 1'b1;
							done_d       = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						if (stat.empty) begin
							cmd.set_none = 1'b1;
							done_d       = 1'b1;
						end else begin
							state_d = S_POPRD;
						end
					end
				end
			end
			S_SCAN: begin
				if (stat.scan_end) begin
					cmd.append = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.scan_ev = 1'b1;
				state_d     = S_SCAN;
			end
			S_POPRD: begin
				state_d = S_POPEV;
			end
			S_POPEV: begin
				cmd.pop_ev = 1'b1;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== hw/rtl/clrq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrq_dp
// Queue storage (circular, one read and one write port), head, walk
// registers and result registers.
// ----------------------------------------------------------------------------
module clrq_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  clrq_pkg::dp_cmd_t                    cmd,
	input  logic [clrq_pkg::SECTOR_W-1:0]        request_sector,
	input  logic [clrq_pkg::LENGTH_W-1:0]        request_length,
	input  logic [clrq_pkg::TAG_W-1:0]           request_tag,
	output clrq_pkg::dp_stat_t                   stat,
	output logic [clrq_pkg::STATUS_W-1:0]        status,
	output logic [clrq_pkg::SECTOR_W-1:0]        out_sector,
	output logic [clrq_pkg::LENGTH_W-1:0]        out_length,
	output logic [clrq_pkg::TAG_W-1:0]           out_tag,
	output logic                                 queue_empty
);

	localparam int IW = clrq_pkg::IDX_W;
	localparam int CW = clrq_pkg::CNT_W;
	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(clrq_pkg::QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(clrq_pkg::QUEUE_DEPTH);
	localparam logic [IW:0]   DEPTH_B = (IW + 1)'(clrq_pkg::QUEUE_DEPTH);

	clrq_pkg::entry_t mem [clrq_pkg::QUEUE_DEPTH];
	clrq_pkg::entry_t rd_q;
	clrq_pkg::entry_t carry_q;

	logic [IW-1:0]                 base_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic                          found_q;
	logic [clrq_pkg::SECTOR_W-1:0] new_sector_q;
	logic [clrq_pkg::SECTOR_W-1:0] head_q;

	logic [clrq_pkg::STATUS_W-1:0] status_q;
	clrq_pkg::entry_t              res_q;
	logic                          empty_q;

	logic [CW:0]                   addr_sum;
	logic [IW-1:0]                 addr;
	logic [IW:0]                   base_inc;
	logic                          hit;
	logic                          we;
	logic [clrq_pkg::SECTOR_W:0]   end_sum;
	logic [clrq_pkg::SECTOR_W-1:0] end_sat;

	// physical slot of logical position idx
	always_comb begin
		addr_sum = {1'b0, (CW - IW)'(0), base_q} + {1'b0, idx_q};
		if (addr_sum >= DEPTH_X) begin
			addr_sum = addr_sum - DEPTH_X;
		end
		addr = addr_sum[IW-1:0];
	end

	always_comb begin
		base_inc = {1'b0, base_q} + (IW + 1)'(1);
		if (base_inc >= DEPTH_B) begin
			base_inc = '0;
		end
	end

	// C-LOOK slot test: slot already found, or entry beyond new word and
	// new word ahead of head or entry strictly behind it
	assign hit = found_q ||
		((rd_q.sector > new_sector_q) &&
		 ((new_sector_q > head_q) || (rd_q.sector < head_q)));

	assign we = cmd.append || (cmd.scan_ev && hit);

	assign end_sum = {1'b0, rd_q.sector} +
		{(clrq_pkg::SECTOR_W + 1 - clrq_pkg::LENGTH_W)'(0), rd_q.length};
	assign end_sat = end_sum[clrq_pkg::SECTOR_W] ? '1 : end_sum[clrq_pkg::SECTOR_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= carry_q;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			carry_q.sector <= request_sector;
			carry_q.length <= request_length;
			carry_q.tag    <= request_tag;
			new_sector_q   <= request_sector;
		end else if (cmd.scan_ev && hit) begin
			carry_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			head_q   <= '0;
			status_q <= clrq_pkg::ST_ADDED;
			res_q    <= '0;
			empty_q  <= 1'b1;
		end else begin
			if (cmd.latch) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_ev) begin
				idx_q <= idx_q + CW'(1);
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.append) begin
				count_q  <= count_q + CW'(1);
				status_q <= clrq_pkg::ST_ADDED;
				res_q    <= '0;
				empty_q  <= 1'b0;
			end
			if (cmd.pop_ev) begin
				base_q   <= base_inc[IW-1:0];
				count_q  <= count_q - CW'(1);
				head_q   <= end_sat;
				status_q <= clrq_pkg::ST_DISPATCHED;
				res_q    <= rd_q;
				empty_q  <= (count_q == CW'(1));
			end
			if (cmd.set_full) begin
				status_q <= clrq_pkg::ST_FULL;
				res_q    <= '0;
				empty_q  <= (count_q == '0);
			end
			if (cmd.set_none) begin
				status_q <= clrq_pkg::ST_NONE;
				res_q    <= '0;
				empty_q  <= 1'b1;
			end
		end
	end

	assign stat.full     = (count_q == DEPTH_C);
	assign stat.empty    = (count_q == '0);
	assign stat.scan_end = (idx_q == count_q);

	assign status      = status_q;
	assign out_sector  = res_q.sector;
	assign out_length  = res_q.length;
	assign out_tag     = res_q.tag;
	assign queue_empty = empty_q;

endmodule

// ===== hw/rtl/clook_request_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clook_request_queue_top
// C-LOOK disk request scheduler: ordered request queue plus head position.
// ----------------------------------------------------------------------------
//  channel  | handshake           | word
//  ---------+---------------------+----------------------------------------
//  command  | start, busy         | command, request_sector/_length/_tag
//  result   | done (1-cycle)      | status, out_sector/_length/_tag,
//           |                     | queue_empty
//
//  A word is taken on start && !busy; its result shows on done in the cycle
//  after the last working cycle. Add: one read and one compare/shift per
//  queued entry through the single-port walk; dispatch: read, then take the
//  front entry; refusal or empty dispatch: busy stays low.
//  Reset empties the queue and sets the head to zero; no clearing pass.
//  Results cannot be held off: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module clook_request_queue_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [clrq_pkg::SECTOR_W-1:0]        request_sector,
	input  logic [clrq_pkg::LENGTH_W-1:0]        request_length,
	input  logic [clrq_pkg::TAG_W-1:0]           request_tag,
	output logic                                 done,
	output logic [clrq_pkg::STATUS_W-1:0]        status,
	output logic [clrq_pkg::SECTOR_W-1:0]        out_sector,
	output logic [clrq_pkg::LENGTH_W-1:0]        out_length,
	output logic [clrq_pkg::TAG_W-1:0]           out_tag,
	output logic                                 queue_empty
);

	clrq_pkg::dp_cmd_t  cmd;
	clrq_pkg::dp_stat_t stat;

	clrq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	clrq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.request_sector (request_sector),
		.request_length (request_length),
		.request_tag    (request_tag),
		.stat           (stat),
		.status         (status),
		.out_sector     (out_sector),
		.out_length     (out_length),
		.out_tag        (out_tag),
		.queue_empty    (queue_empty)
	);

endmodule

// ===== hw/rtl/clrq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrq_checker
// Port-level checks on the request queue results.
// ----------------------------------------------------------------------------
module clrq_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [clrq_pkg::STATUS_W-1:0]        status,
	input logic [clrq_pkg::SECTOR_W-1:0]        out_sector,
	input logic [clrq_pkg::LENGTH_W-1:0]        out_length,
	input logic [clrq_pkg::TAG_W-1:0]           out_tag,
	input logic                                 queue_empty
);

	// a result only follows an accepted word or a working cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a preceding word");

	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == clrq_pkg::ST_NONE) |-> queue_empty)
		else $error("nothing to dispatch but queue not empty");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == clrq_pkg::ST_FULL || status == clrq_pkg::ST_ADDED))
			|-> !queue_empty)
		else $error("queue empty after add or refusal");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != clrq_pkg::ST_DISPATCHED)
			|-> (out_sector == '0 && out_length == '0 && out_tag == '0))
		else $error("request fields set on a non-dispatch result");

endmodule

bind clook_request_queue_top clrq_checker u_clrq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_sector  (out_sector),
	.out_length  (out_length),
	.out_tag     (out_tag),
	.queue_empty (queue_empty)
);
